[hw/rtl/jadc_pkg.sv]
// shared types, register map and constants for the joystick axis conditioner
package jadc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int APB_ADDR_W = 5;
    localparam int DIV_NUM_W  = 28;
    localparam int DIV_CNT_W  = 5;

    // register index, taken from paddr word address
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_CENTER_POS        = 3'd0;
    localparam t_reg_idx REG_LEFT_LIMIT        = 3'd1;
    localparam t_reg_idx REG_RIGHT_LIMIT       = 3'd2;
    localparam t_reg_idx REG_NULL_HALF_WIDTH   = 3'd3;
    localparam t_reg_idx REG_CALIBRATE_ENABLE  = 3'd4;
    localparam t_reg_idx REG_JITTER_MARGIN     = 3'd5;
    localparam t_reg_idx REG_JITTER_RESISTANCE = 3'd6;
    localparam t_reg_idx REG_JITTER_ENABLE     = 3'd7;

    localparam logic [SAMPLE_W-1:0]  AXIS_CENTRE = 16'd1024;
    localparam int                   MAP_SHIFT   = 10;   // *2048 / 2
    localparam logic [DIV_CNT_W-1:0] DIV1_STEPS  = 5'd17;
    localparam logic [DIV_CNT_W-1:0] DIV2_STEPS  = 5'd28;

    typedef struct packed {
        logic [15:0] center_pos;
        logic [15:0] left_limit;
        logic [15:0] right_limit;
        logic [15:0] null_half_width;
        logic        calibrate_enable;
        logic [15:0] jitter_margin;
        logic [7:0]  jitter_resistance;
        logic        jitter_enable;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        center_pos:        16'd32768,
        left_limit:        16'd0,
        right_limit:       16'd65535,
        null_half_width:   16'd0,
        calibrate_enable:  1'b0,
        jitter_margin:     16'd0,
        jitter_resistance: 8'd0,
        jitter_enable:     1'b0
    };

    typedef struct packed {
        logic                  start;
        logic [DIV_CNT_W-1:0]  steps;
        logic [15:0]           rem_init;
        logic [DIV_NUM_W-1:0]  num;
        logic [15:0]           divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIV_NUM_W-1:0]  quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GEOM,
        S_SIDE,
        S_MUL,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_MAP,
        S_DIV2_GO,
        S_DIV2_WAIT,
        S_DONE
    } t_state;

endpackage

[hw/rtl/joystick_axis_dejitter_calibrate_top.sv]
// top level: one joystick axis conditioner with apb settings port
// calibration off passes the filtered sample on; the dead zone posts the centre value;
//   else one radix-2 divider maps it (28 steps), after a 17-step pass on the wider side
// one transaction at a time: ready only when idle, after the last result is posted
// a finished result waits in the output register while the next sample is taken
// reset: synchronous active low, settings return to defaults and hold filter state to zero
module joystick_axis_dejitter_calibrate_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_sample_valid,
    output logic                            o_sample_ready,
    input  logic [jadc_pkg::SAMPLE_W-1:0]   i_raw_sample,
    output logic                            o_result_valid,
    input  logic                            i_result_ready,
    output logic [jadc_pkg::SAMPLE_W-1:0]   o_axis_value,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jadc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import jadc_pkg::*;

    t_cfg cfg;

    jadc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    jadc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (i_sample_valid),
        .o_ready      (o_sample_ready),
        .i_raw_sample (i_raw_sample),
        .o_valid      (o_result_valid),
        .i_ready      (i_result_ready),
        .o_axis_value (o_axis_value)
    );

endmodule

[hw/rtl/jadc_div.sv]
// iterative restoring divider, one quotient bit per cycle
module jadc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jadc_pkg::t_div_req i_req,
    output jadc_pkg::t_div_rsp o_rsp
);
    import jadc_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt,  n_cnt;
    logic [15:0]          r_rem,  n_rem;
    logic [DIV_NUM_W-1:0] r_quot, n_quot;
    logic [15:0]          r_div,  n_div;
    logic [16:0]          trial;
    logic [16:0]          diff;

    always_comb begin
        trial  = {r_rem, r_quot[DIV_NUM_W-1]};
        diff   = trial - {1'b0, r_div};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_div  = r_div;
        if (i_req.start) begin
            // remainder starts below the divisor, so the quotient fits the step count
            n_busy = 1'b1;
            n_cnt  = i_req.steps;
            n_rem  = i_req.rem_init;
            n_quot = i_req.num;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem  = diff[15:0];
                n_quot = {r_quot[DIV_NUM_W-2:0], 1'b1};
            end else begin
                n_rem  = trial[15:0];
                n_quot = {r_quot[DIV_NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_div  <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy)
        else $error("divider did not start");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

endmodule

[hw/rtl/jadc_cfg.sv]
// apb register file holding the axis settings
module jadc_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jadc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output jadc_pkg::t_cfg                  o_cfg
);
    import jadc_pkg::*;

    t_cfg     r_cfg, n_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                REG_CENTER_POS:        n_cfg.center_pos        = pwdata[15:0];
                REG_LEFT_LIMIT:        n_cfg.left_limit        = pwdata[15:0];
                REG_RIGHT_LIMIT:       n_cfg.right_limit       = pwdata[15:0];
                REG_NULL_HALF_WIDTH:   n_cfg.null_half_width   = pwdata[15:0];
                REG_CALIBRATE_ENABLE:  n_cfg.calibrate_enable  = pwdata[0];
                REG_JITTER_MARGIN:     n_cfg.jitter_margin     = pwdata[15:0];
                REG_JITTER_RESISTANCE: n_cfg.jitter_resistance = pwdata[7:0];
                REG_JITTER_ENABLE:     n_cfg.jitter_enable     = pwdata[0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_CENTER_POS:        prdata = {16'd0, r_cfg.center_pos};
            REG_LEFT_LIMIT:        prdata = {16'd0, r_cfg.left_limit};
            REG_RIGHT_LIMIT:       prdata = {16'd0, r_cfg.right_limit};
            REG_NULL_HALF_WIDTH:   prdata = {16'd0, r_cfg.null_half_width};
            REG_CALIBRATE_ENABLE:  prdata = {31'd0, r_cfg.calibrate_enable};
            REG_JITTER_MARGIN:     prdata = {16'd0, r_cfg.jitter_margin};
            REG_JITTER_RESISTANCE: prdata = {24'd0, r_cfg.jitter_resistance};
            REG_JITTER_ENABLE:     prdata = {31'd0, r_cfg.jitter_enable};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/jadc_core.sv]
// hold filter and calibration sequencer driving the shared divider
module jadc_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  jadc_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [jadc_pkg::SAMPLE_W-1:0] i_raw_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [jadc_pkg::SAMPLE_W-1:0] o_axis_value
);
    import jadc_pkg::*;

    t_state r_state, n_state;

    // filter state
    logic [15:0] r_held, n_held;
    logic [7:0]  r_rep,  n_rep;

    // datapath
    logic [15:0]        r_p;
    logic signed [17:0] r_lo, r_hi;
    logic [15:0]        r_w1, r_w2, r_w;
    logic               r_inzone;
    logic               r_sneg;
    logic [16:0]        r_smag;
    logic [15:0]        r_wl, r_ws;
    logic [32:0]        r_prod;
    logic               r_mneg;
    logic [17:0]        r_mmag;
    logic [15:0]        r_res;
    logic               r_ovalid, n_ovalid;
    logic [15:0]        r_oval;

    logic      accept;
    logic      out_load;
    t_div_req  div_req;
    t_div_rsp  div_rsp;

    // filter
    logic [16:0] band_lo, band_hi;
    logic        outside;
    logic [15:0] filt_p;

    // geometry
    logic signed [17:0] p_s, lo_c, hi_c;
    logic [15:0]        w1_c, w2_c;

    // side selection
    logic [15:0]        pc_a, pc;
    logic               left_c;
    logic signed [17:0] pc_s, d_c, dabs;
    logic               dneg;
    logic               scale_c;

    // mapping
    logic [17:0] ext_s, ext_w;
    logic [17:0] m_c;
    logic        mneg_c;
    logic [15:0] q16;
    logic [15:0] res_c;

    jadc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // anti-jitter hold
    always_comb begin
        band_lo = {1'b0, i_raw_sample} + {1'b0, i_cfg.jitter_margin};
        band_hi = {1'b0, r_held} + {1'b0, i_cfg.jitter_margin};
        outside = (band_lo < {1'b0, r_held}) || ({1'b0, i_raw_sample} > band_hi);
        filt_p  = i_raw_sample;
        n_held  = r_held;
        n_rep   = r_rep;
        if (accept && i_cfg.jitter_enable) begin
            priority if (outside) begin
                n_rep  = '0;
                n_held = i_raw_sample;
            end else if (r_rep < i_cfg.jitter_resistance) begin
                n_rep  = r_rep + 8'd1;
                filt_p = r_held;
            end else begin
                n_rep  = '0;
                n_held = i_raw_sample;
            end
        end
    end

    // zone bounds and side widths, widths wrap to 16 bits
    always_comb begin
        p_s  = signed'({2'b00, r_p});
        lo_c = signed'({2'b00, i_cfg.center_pos}) - signed'({2'b00, i_cfg.null_half_width});
        hi_c = signed'({2'b00, i_cfg.center_pos}) + signed'({2'b00, i_cfg.null_half_width});
        w1_c = i_cfg.center_pos - i_cfg.null_half_width - i_cfg.left_limit;
        w2_c = i_cfg.right_limit - i_cfg.center_pos - i_cfg.null_half_width;
    end

    // clamp, right limit applied last so it wins on inverted limits
    always_comb begin
        pc_a    = (r_p < i_cfg.left_limit) ? i_cfg.left_limit : r_p;
        pc      = (pc_a > i_cfg.right_limit) ? i_cfg.right_limit : pc_a;
        left_c  = pc < i_cfg.center_pos;
        pc_s    = signed'({2'b00, pc});
        d_c     = left_c ? (r_lo - pc_s) : (pc_s - r_hi);
        dneg    = d_c[17];
        dabs    = dneg ? -d_c : d_c;
        scale_c = left_c ? (r_w1 > r_w2) : (r_w2 > r_w1);
    end

    // offset by w in sign-magnitude form
    always_comb begin
        ext_s = {1'b0, r_smag};
        ext_w = {2'b00, r_w};
        if (!r_sneg) begin
            m_c    = ext_s + ext_w;
            mneg_c = 1'b0;
        end else if (ext_s <= ext_w) begin
            m_c    = ext_w - ext_s;
            mneg_c = 1'b0;
        end else begin
            m_c    = ext_s - ext_w;
            mneg_c = 1'b1;
        end
        q16   = div_rsp.quot[15:0];
        res_c = r_mneg ? (~q16 + 16'd1) : q16;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_cfg.calibrate_enable ? S_GEOM : S_DONE;
                end
            end
            S_GEOM: n_state = S_SIDE;
            S_SIDE: begin
                priority if (r_inzone || (r_w == 16'd0)) begin
                    n_state = S_DONE;
                end else if (scale_c) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_MAP;
                end
            end
            S_MUL:       n_state = S_DIV1_GO;
            S_DIV1_GO:   n_state = S_DIV1_WAIT;
            S_DIV1_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_MAP;
                end
            end
            S_MAP:       n_state = S_DIV2_GO;
            S_DIV2_GO:   n_state = S_DIV2_WAIT;
            S_DIV2_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and divider requests
    always_comb begin
        o_ready          = (r_state == S_IDLE);
        out_load         = (r_state == S_DONE) && (!r_ovalid || i_ready);
        div_req.start    = (r_state == S_DIV1_GO) || (r_state == S_DIV2_GO);
        if (r_state == S_DIV2_GO) begin
            div_req.steps    = DIV2_STEPS;
            div_req.rem_init = '0;
            div_req.num      = {r_mmag, {MAP_SHIFT{1'b0}}};
            div_req.divisor  = r_w;
        end else begin
            // product is below wl * 2^17, so its top bits start the remainder
            div_req.steps    = DIV1_STEPS;
            div_req.rem_init = r_prod[32:17];
            div_req.num      = {r_prod[16:0], 11'd0};
            div_req.divisor  = r_wl;
        end
    end

    assign accept   = i_valid && o_ready;
    assign n_ovalid = out_load || (r_ovalid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_held   <= '0;
            r_rep    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_held   <= n_held;
            r_rep    <= n_rep;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_p   <= filt_p;
                    r_res <= filt_p;
                end
            end
            S_GEOM: begin
                r_lo     <= lo_c;
                r_hi     <= hi_c;
                r_w1     <= w1_c;
                r_w2     <= w2_c;
                r_w      <= (w2_c > w1_c) ? w1_c : w2_c;
                r_inzone <= (p_s >= lo_c) && (p_s <= hi_c);
            end
            S_SIDE: begin
                r_res  <= AXIS_CENTRE;
                r_smag <= dabs[16:0];
                // left side is negated after scaling
                r_sneg <= left_c ? !dneg : dneg;
                r_wl   <= left_c ? r_w1 : r_w2;
                r_ws   <= left_c ? r_w2 : r_w1;
            end
            S_MUL: r_prod <= 33'(r_smag) * 33'(r_ws);
            S_DIV1_WAIT: begin
                if (div_rsp.done) begin
                    r_smag <= div_rsp.quot[16:0];
                end
            end
            S_MAP: begin
                r_mneg <= mneg_c;
                r_mmag <= m_c;
            end
            S_DIV2_WAIT: begin
                if (div_rsp.done) begin
                    r_res <= res_c;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    r_oval <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid      = r_ovalid;
    assign o_axis_value = r_oval;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("ready high right after a transaction was taken");

    a_div_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (div_req.rem_init < div_req.divisor))
        else $error("divider started with quotient overflow");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV1_WAIT || r_state == S_DIV2_WAIT))
        else $error("divider finished while sequencer not waiting");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_ovalid) |=> r_ovalid)
        else $error("finished result not posted to output register");

endmodule
